### hw/rtl/pcbc_pkg.sv
// shared types and constants for the point-cloud box centroid block
package pcbc_pkg;

  localparam int unsigned MAX_POINTS = 524288;
  localparam int unsigned CNT_W = 20;
  localparam int unsigned SUM_W = 36;
  localparam int unsigned PROJ_W = 64;
  localparam int unsigned NUM_W = 65;

  localparam logic [2:0] REG_ROW0_A = 3'd0;
  localparam logic [2:0] REG_ROW0_B = 3'd1;
  localparam logic [2:0] REG_ROW1_A = 3'd2;
  localparam logic [2:0] REG_ROW1_B = 3'd3;
  localparam logic [2:0] REG_ROW2_A = 3'd4;
  localparam logic [2:0] REG_ROW2_B = 3'd5;
  localparam logic [2:0] REG_BOX_ORIGIN = 3'd6;
  localparam logic [2:0] REG_BOX_SIZE = 3'd7;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               point_valid;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic [CNT_W-1:0]   point_count;
    logic               empty_res;
    logic               overflow;
  } out_item_t;

  // projected item handed from front to back
  typedef struct packed {
    logic signed [15:0]       x;
    logic signed [15:0]       y;
    logic signed [15:0]       z;
    logic signed [PROJ_W-1:0] p0;
    logic signed [PROJ_W-1:0] p1;
    logic signed [PROJ_W-1:0] p2;
    logic                     valid;
    logic                     last;
  } proj_item_t;

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] w;
    logic [15:0] h;
  } box_t;

endpackage

### hw/rtl/pcbc_front.sv
// front end: accepts points and projects them through the matrix
module pcbc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          proj [6],
  input  pcbc_pkg::in_item_t   in_item,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pcbc_pkg::proj_item_t pi,
  output logic                 pi_valid,
  input  logic                 pi_ready
);
  import pcbc_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001, F_MUL = 4'b0010, F_SUM = 4'b0100, F_OUT = 4'b1000
  } fstate_t;

  fstate_t state;
  in_item_t item;
  logic [1:0] row;
  logic signed [63:0] prod0, prod1, prod2, off;
  logic signed [PROJ_W-1:0] p0, p1, p2;
  logic [63:0] ra, rb;

  assign in_ready = (state == F_IDLE);
  assign pi_valid = (state == F_OUT);
  assign ra = proj[{row, 1'b0}];
  assign rb = proj[{row, 1'b1}];

  // one row per pass: three products registered, then summed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      row <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            row <= 2'd0;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod0 <= $signed(ra[31:0]) * 64'(item.point_x);
          prod1 <= $signed(ra[63:32]) * 64'(item.point_y);
          prod2 <= $signed(rb[31:0]) * 64'(item.point_z);
          off <= 64'($signed(rb[63:32]));
          state <= F_SUM;
        end
        F_SUM: begin
          case (row)
            2'd0: p0 <= prod0 + prod1 + prod2 + off;
            2'd1: p1 <= prod0 + prod1 + prod2 + off;
            default: p2 <= prod0 + prod1 + prod2 + off;
          endcase
          if (row == 2'd2) begin
            state <= F_OUT;
          end else begin
            row <= row + 2'd1;
            state <= F_MUL;
          end
        end
        F_OUT: begin
          if (pi_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    pi.x = item.point_x;
    pi.y = item.point_y;
    pi.z = item.point_z;
    pi.p0 = p0;
    pi.p1 = p1;
    pi.p2 = p2;
    pi.valid = item.point_valid;
    pi.last = item.frame_last;
  end
endmodule

### hw/rtl/pcbc_queue.sv
// two-entry queue between front and back
module pcbc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  pcbc_pkg::proj_item_t wr_data,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  output pcbc_pkg::proj_item_t rd_data,
  output logic                 rd_valid,
  input  logic                 rd_ready
);
  import pcbc_pkg::*;

  proj_item_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  logic do_wr, do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

### hw/rtl/pcbc_back.sv
// back end: pixel divide, box test, accumulation and mean
module pcbc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pcbc_pkg::box_t        box,
  input  pcbc_pkg::proj_item_t  pi,
  input  logic                  pi_valid,
  output logic                  pi_ready,
  output pcbc_pkg::out_item_t   res,
  output logic                  res_valid,
  input  logic                  res_ready
);
  import pcbc_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001, B_DIV = 6'b000010, B_TEST = 6'b000100,
    B_MEAN = 6'b001000, B_DONE = 6'b010000, B_OUT = 6'b100000
  } bstate_t;

  bstate_t state;
  proj_item_t item;
  logic [SUM_W-1:0] sum_px, sum_py, sum_pz;
  logic [CNT_W-1:0] selected_count;
  logic overflow_seen;

  // two restoring dividers, both used for pixel division; the first is reused for mean division
  logic [NUM_W-1:0] quo0, quo1, rem0, rem1, den;
  logic neg0, neg1;
  logic [6:0] cnt;
  logic [1:0] mcnt;
  logic [NUM_W:0] t0, t1;
  logic [NUM_W-1:0] mag0, mag1;
  logic signed [NUM_W:0] u, v;
  logic signed [SUM_W-1:0] cur_sum;
  logic [SUM_W-1:0] mag_sum;
  logic [15:0] means [3];
  logic in_box;

  assign t0 = {rem0, quo0[NUM_W-1]} - {1'b0, den};
  assign t1 = {rem1, quo1[NUM_W-1]} - {1'b0, den};
  assign mag0 = item.p0[PROJ_W-1] ? NUM_W'(-{item.p0[PROJ_W-1], item.p0})
                                  : NUM_W'(item.p0);
  assign mag1 = item.p1[PROJ_W-1] ? NUM_W'(-{item.p1[PROJ_W-1], item.p1})
                                  : NUM_W'(item.p1);

  // floor for negative numerators: -(q + (r != 0))
  always_comb begin
    u = neg0 ? -$signed({1'b0, quo0} + (NUM_W+1)'(rem0 != '0))
             : $signed({1'b0, quo0});
    v = neg1 ? -$signed({1'b0, quo1} + (NUM_W+1)'(rem1 != '0))
             : $signed({1'b0, quo1});
    in_box = (u >= $signed((NUM_W+1)'(box.x0)))
          && (u < $signed((NUM_W+1)'({1'b0, box.x0} + {1'b0, box.w})))
          && (v >= $signed((NUM_W+1)'(box.y0)))
          && (v < $signed((NUM_W+1)'({1'b0, box.y0} + {1'b0, box.h})));
  end

  always_comb begin
    case (mcnt)
      2'd0: cur_sum = $signed(sum_px);
      2'd1: cur_sum = $signed(sum_py);
      default: cur_sum = $signed(sum_pz);
    endcase
    mag_sum = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
  end

  assign pi_ready = (state == B_IDLE);
  assign res_valid = (state == B_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      sum_px <= '0;
      sum_py <= '0;
      sum_pz <= '0;
      selected_count <= '0;
      overflow_seen <= 1'b0;
      cnt <= '0;
      mcnt <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (pi_valid) begin
            item <= pi;
            if (pi.valid && pi.p2 > 0) begin
              den <= NUM_W'(pi.p2);
              quo0 <= '0;
              quo1 <= '0;
              rem0 <= '0;
              rem1 <= '0;
              cnt <= 7'd0;
              state <= B_DIV;
            end else if (pi.last) begin
              mcnt <= 2'd0;
              cnt <= 7'd0;
              state <= B_MEAN;
            end
          end
        end
        B_DIV: begin
          if (cnt == 7'd0) begin
            quo0 <= mag0;
            quo1 <= mag1;
            neg0 <= item.p0[PROJ_W-1];
            neg1 <= item.p1[PROJ_W-1];
            cnt <= 7'd1;
          end else begin
            quo0 <= {quo0[NUM_W-2:0], ~t0[NUM_W]};
            quo1 <= {quo1[NUM_W-2:0], ~t1[NUM_W]};
            rem0 <= t0[NUM_W] ? {rem0[NUM_W-2:0], quo0[NUM_W-1]} : t0[NUM_W-1:0];
            rem1 <= t1[NUM_W] ? {rem1[NUM_W-2:0], quo1[NUM_W-1]} : t1[NUM_W-1:0];
            if (cnt == 7'(NUM_W)) state <= B_TEST;
            else cnt <= cnt + 7'd1;
          end
        end
        B_TEST: begin
          if (in_box) begin
            if (selected_count >= CNT_W'(MAX_POINTS)) begin
              overflow_seen <= 1'b1;
            end else begin
              sum_px <= sum_px + SUM_W'(item.x);
              sum_py <= sum_py + SUM_W'(item.y);
              sum_pz <= sum_pz + SUM_W'(item.z);
              selected_count <= selected_count + 1'b1;
            end
          end
          mcnt <= 2'd0;
          cnt <= 7'd0;
          state <= item.last ? B_MEAN : B_IDLE;
        end
        // three serial divides of |sum| by count, one bit per cycle
        B_MEAN: begin
          if (cnt == 7'd0) begin
            quo0 <= NUM_W'(mag_sum) << (NUM_W - SUM_W);
            rem0 <= '0;
            den <= NUM_W'(selected_count);
            neg0 <= cur_sum[SUM_W-1];
            cnt <= 7'd1;
          end else begin
            quo0 <= {quo0[NUM_W-2:0], ~t0[NUM_W]};
            rem0 <= t0[NUM_W] ? {rem0[NUM_W-2:0], quo0[NUM_W-1]} : t0[NUM_W-1:0];
            if (cnt == 7'(SUM_W)) state <= B_DONE;
            else cnt <= cnt + 7'd1;
          end
        end
        B_DONE: begin
          if (selected_count == '0) means[mcnt] <= '0;
          else means[mcnt] <= neg0 ? 16'(-quo0) : quo0[15:0];
          cnt <= 7'd0;
          if (mcnt == 2'd2) begin
            state <= B_OUT;
          end else begin
            mcnt <= mcnt + 2'd1;
            state <= B_MEAN;
          end
        end
        B_OUT: begin
          if (res_ready) begin
            sum_px <= '0;
            sum_py <= '0;
            sum_pz <= '0;
            selected_count <= '0;
            overflow_seen <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_comb begin
    res.mean_x = means[0];
    res.mean_y = means[1];
    res.mean_z = means[2];
    res.point_count = selected_count;
    res.empty_res = (selected_count == '0);
    res.overflow = overflow_seen;
  end
endmodule

### hw/rtl/point_cloud_box_centroid.sv
// Point-cloud box centroid: each request is one 3D point, projected through a
// 3x4 Q16.16 matrix, divided to pixel u and v with floor, and summed when it
// lands inside the box; a frame_last request yields one result with the mean,
// count, empty and overflow flags. The front projects the three rows one by
// one, each as registered products and then a sum; the back divides a valid
// point with positive depth to pixels with one-bit-per-cycle dividers, and a
// frame end adds the three mean divisions on the first of them. A two-entry
// queue between the two halves lets either stall independently.
module point_cloud_box_centroid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcbc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcbc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import pcbc_pkg::*;

  logic [63:0] proj [6];
  box_t box;
  proj_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) proj[i] <= '0;
      box <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW0_A, REG_ROW0_B, REG_ROW1_A, REG_ROW1_B, REG_ROW2_A, REG_ROW2_B:
          proj[cfg_index] <= cfg_data;
        REG_BOX_ORIGIN: begin
          box.x0 <= cfg_data[15:0];
          box.y0 <= cfg_data[31:16];
        end
        REG_BOX_SIZE: begin
          box.w <= cfg_data[15:0];
          box.h <= cfg_data[31:16];
        end
        default: ;
      endcase
    end
  end

  pcbc_front u_front (
    .clk(clk), .rst(rst), .proj(proj), .in_item(in_data), .in_valid(in_valid),
    .in_ready(in_ready), .pi(f_item), .pi_valid(f_valid), .pi_ready(f_ready)
  );

  pcbc_queue u_queue (
    .clk(clk), .rst(rst), .wr_data(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_item), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  pcbc_back u_back (
    .clk(clk), .rst(rst), .box(box), .pi(q_item), .pi_valid(q_valid),
    .pi_ready(q_ready), .res(out_data), .res_valid(out_valid), .res_ready(out_ready)
  );

  // result flags agree with the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.empty_res == (out_data.point_count == '0)))
    else $error("empty flag disagrees with count");

  // count never passes the limit
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.point_count <= CNT_W'(MAX_POINTS)))
    else $error("count above limit");

  // an empty result carries zero means
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_res) |->
      (out_data.mean_x == '0 && out_data.mean_y == '0 && out_data.mean_z == '0))
    else $error("empty result with nonzero mean");
endmodule

### tb/point_cloud_box_centroid_check.sv
// result checker for the point-cloud box centroid block: predicts centroids and compares
module point_cloud_box_centroid_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pcbc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pcbc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  pending,
  output int                  errors
);
  import pcbc_pkg::*;

  // shadow copy of the block's registers and accumulators
  logic [63:0]        proj_coef [6];
  logic [31:0]        box_org;
  logic [31:0]        box_dim;
  logic signed [35:0] acc_x, acc_y, acc_z;
  logic [CNT_W-1:0]   hit_count;
  logic               hit_overflow;
  out_item_t          centroid_q [$];

  assign pending = centroid_q.size();

  // one row of the projection, exact in 64 bits
  function automatic longint project(int row, longint x, longint y, longint z);
    logic [63:0] a;
    logic [63:0] b;
    a = proj_coef[row * 2];
    b = proj_coef[row * 2 + 1];
    return longint'($signed(a[31:0])) * x + longint'($signed(a[63:32])) * y +
           longint'($signed(b[31:0])) * z + longint'($signed(b[63:32]));
  endfunction

  // floor division for a positive divisor
  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic [15:0] mean_of(logic signed [35:0] sum, logic [CNT_W-1:0] cnt);
    longint q;
    if (cnt == 0) return 16'd0;
    q = longint'(sum) / longint'(cnt);
    return q[15:0];
  endfunction

  always @(posedge clk) begin : watch
    longint    px, py, pz, pu, pv;
    longint    x0, y0, wd, ht;
    out_item_t want;
    if (rst) begin
      foreach (proj_coef[i]) proj_coef[i] = '0;
      box_org = '0;
      box_dim = '0;
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
      hit_count = '0;
      hit_overflow = 1'b0;
      centroid_q.delete();
      errors = 0;
    end else begin
      // compare a delivered centroid with the oldest prediction
      if (out_valid && out_ready) begin
        if (centroid_q.size() == 0) begin
          $error("unexpected result: mean_x %0d count %0d", out_data.mean_x,
                 out_data.point_count);
          errors++;
        end else begin
          want = centroid_q.pop_front();
          if (out_data.mean_x !== want.mean_x) begin
            $error("mean_x expected %0d got %0d", want.mean_x, out_data.mean_x);
            errors++;
          end
          if (out_data.mean_y !== want.mean_y) begin
            $error("mean_y expected %0d got %0d", want.mean_y, out_data.mean_y);
            errors++;
          end
          if (out_data.mean_z !== want.mean_z) begin
            $error("mean_z expected %0d got %0d", want.mean_z, out_data.mean_z);
            errors++;
          end
          if (out_data.point_count !== want.point_count) begin
            $error("point_count expected %0d got %0d", want.point_count,
                   out_data.point_count);
            errors++;
          end
          if (out_data.empty_res !== want.empty_res) begin
            $error("empty_res expected %0d got %0d", want.empty_res, out_data.empty_res);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow expected %0d got %0d", want.overflow, out_data.overflow);
            errors++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOX_ORIGIN: box_org = cfg_data[31:0];
          REG_BOX_SIZE:   box_dim = cfg_data[31:0];
          default:        proj_coef[cfg_index] = cfg_data;
        endcase
      end

      // accumulate an accepted point, emit a prediction on frame end
      if (in_valid && in_ready) begin
        if (in_data.point_valid) begin
          px = project(0, in_data.point_x, in_data.point_y, in_data.point_z);
          py = project(1, in_data.point_x, in_data.point_y, in_data.point_z);
          pz = project(2, in_data.point_x, in_data.point_y, in_data.point_z);
          if (pz > 0) begin
            pu = floor_div(px, pz);
            pv = floor_div(py, pz);
            x0 = box_org[15:0];
            y0 = box_org[31:16];
            wd = box_dim[15:0];
            ht = box_dim[31:16];
            if (pu >= x0 && pu < x0 + wd && pv >= y0 && pv < y0 + ht) begin
              if (hit_count >= MAX_POINTS) begin
                hit_overflow = 1'b1;
              end else begin
                acc_x = acc_x + in_data.point_x;
                acc_y = acc_y + in_data.point_y;
                acc_z = acc_z + in_data.point_z;
                hit_count = hit_count + 1'b1;
              end
            end
          end
        end
        if (in_data.frame_last) begin
          want.mean_x = mean_of(acc_x, hit_count);
          want.mean_y = mean_of(acc_y, hit_count);
          want.mean_z = mean_of(acc_z, hit_count);
          want.point_count = hit_count;
          want.empty_res = (hit_count == 0);
          want.overflow = hit_overflow;
          centroid_q = {centroid_q, want};
          acc_x = '0;
          acc_y = '0;
          acc_z = '0;
          hit_count = '0;
          hit_overflow = 1'b0;
        end
      end
    end
  end

endmodule

### tb/point_cloud_box_centroid_test.sv
// stimulus and verdict for the point-cloud box centroid block
module point_cloud_box_centroid_test;
  import pcbc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 300;
  localparam int PHASE_ITEMS = 215;
  localparam int NUM_PHASES = 8;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_CX = 32'h0140_0000;  // 320.0
  localparam logic [31:0] Q_CY = 32'h00F0_0000;  // 240.0

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          pending;
  int          errors;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          cycles = 0;

  point_cloud_box_centroid u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  point_cloud_box_centroid_check u_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all eight registers, then drop the write request
  task automatic load_setup(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                            logic [63:0] r1b, logic [63:0] r2a, logic [63:0] r2b,
                            logic [31:0] origin, logic [31:0] dims);
    write_reg(REG_ROW0_A, r0a);
    write_reg(REG_ROW0_B, r0b);
    write_reg(REG_ROW1_A, r1a);
    write_reg(REG_ROW1_B, r1b);
    write_reg(REG_ROW2_A, r2a);
    write_reg(REG_ROW2_B, r2b);
    write_reg(REG_BOX_ORIGIN, {32'd0, origin});
    write_reg(REG_BOX_SIZE, {32'd0, dims});
    cfg_valid <= 1'b0;
  endtask

  // pinhole-style matrix: u = x/z + 320, v = y/z + 240
  task automatic load_pinhole(logic [31:0] origin, logic [31:0] dims);
    load_setup({32'd0, Q_ONE}, {32'd0, Q_CX}, {Q_ONE, 32'd0}, {32'd0, Q_CY},
               64'd0, {32'd0, Q_ONE}, origin, dims);
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic ok, logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{point_x: x, point_y: y, point_z: z, point_valid: ok, frame_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly points near the box under the pinhole matrix, some raw noise
  task automatic send_random_point();
    int          z;
    int          x;
    int          y;
    logic [47:0] raw;
    z = $urandom_range(1, 3000);
    x = int'($urandom_range(50 * z)) - 25 * z;
    y = int'($urandom_range(50 * z)) - 25 * z;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    raw = {$urandom, $urandom};
    if ($urandom_range(99) < 75)
      send_point(16'(x), 16'(y), 16'(z), $urandom_range(99) < 90,
                 $urandom_range(5) == 0);
    else
      send_point(raw[15:0], raw[31:16], raw[47:32], raw[0] ^ raw[20],
                 $urandom_range(5) == 0);
  endtask

  // let the prediction of the last request land, then drain
  task automatic settle();
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROW0_A;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: box of 40x40 around the image center
    load_pinhole({16'd220, 16'd300}, {16'd40, 16'd40});
    send_point(16'sd100, 16'sd50, 16'sd1000, 1'b1, 1'b0);
    send_point(-16'sd300, -16'sd200, 16'sd999, 1'b1, 1'b0);
    send_point(16'sd5, 16'sd5, 16'sd0, 1'b1, 1'b0);        // zero depth
    send_point(16'sd5, 16'sd5, -16'sd100, 1'b1, 1'b0);     // negative depth
    send_point(16'sd0, 16'sd0, 16'sd500, 1'b0, 1'b0);      // invalid point
    send_point(16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd100, 1'b0, 1'b1);      // empty frame
    send_point(-16'sd7, -16'sd3, 16'sd1, 1'b1, 1'b0);
    send_point(-16'sd8, 16'sd4, 16'sd2, 1'b1, 1'b0);
    send_point(16'sd1, 16'sd1, 16'sd3, 1'b1, 1'b1);        // truncated negative mean
    send_point(16'sd20, 16'sd0, 16'sd1, 1'b1, 1'b0);       // right edge, out
    send_point(-16'sd20, -16'sd20, 16'sd1, 1'b1, 1'b0);    // top-left corner, in
    send_point(16'sd19, 16'sd19, 16'sd1, 1'b1, 1'b1);      // bottom-right corner, in
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b1);
    in_valid <= 1'b0;
    settle();

    // random phases over several register settings and idling patterns
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (phase)
        0: load_pinhole({16'd220, 16'd300}, {16'd40, 16'd40});
        1: load_setup('0, '0, '0, '0, '0, '0, '0, '0);
        2: load_pinhole({16'd200, 16'd280}, {16'd80, 16'd0});
        3: load_pinhole('0, 32'hFFFF_FFFF);
        4: load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom, $urandom);
        5: load_setup({32'd0, -32'sd163840}, {32'h0010_0000, Q_CX},
                      {-32'sd131072, 32'd0}, {-32'sd65536, Q_CY},
                      64'd0, {32'h0000_8000, Q_ONE}, {16'd0, 16'd0}, {16'd600, 16'd700});
        6: load_setup('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: load_pinhole({16'd230, 16'd310}, {16'd20, 16'd20});
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_point();
      send_point(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2000)), 1'b1, 1'b1);
      in_valid <= 1'b0;
      settle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
